// File: hw/rtl/cc20_pkg.sv
// shared constants, types and helper functions for the chacha20 stream cipher
package cc20_pkg;

	// double rounds per keystream block
	localparam int DOUBLE_ROUNDS = 10;
	// the round unit does half a quarter round per lane per cycle
	localparam int ROUND_STEPS = DOUBLE_ROUNDS * 4;
	localparam int STEP_W = $clog2(ROUND_STEPS);

	localparam logic [31:0] SIGMA_0 = 32'h61707865;
	localparam logic [31:0] SIGMA_1 = 32'h3320646e;
	localparam logic [31:0] SIGMA_2 = 32'h79622d32;
	localparam logic [31:0] SIGMA_3 = 32'h6b206574;

	localparam int ROT_A = 16;
	localparam int ROT_B = 12;
	localparam int ROT_C = 8;
	localparam int ROT_D = 7;

	// configuration register map, register i at byte address 8*i
	localparam int ADDR_W = 6;
	localparam logic [2:0] REG_KEY_01   = 3'd0;
	localparam logic [2:0] REG_KEY_23   = 3'd1;
	localparam logic [2:0] REG_KEY_45   = 3'd2;
	localparam logic [2:0] REG_KEY_67   = 3'd3;
	localparam logic [2:0] REG_NONCE_01 = 3'd4;
	localparam logic [2:0] REG_NONCE_2  = 3'd5;
	localparam logic [2:0] REG_START    = 3'd6;

	localparam logic [3:0] MAX_BYTES = 4'd8;

	typedef logic [15:0][31:0] state_t;
	typedef logic [3:0][63:0] key_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic state_t init_state(input key_t key, input logic [63:0] nonce01,
			input logic [31:0] nonce2, input logic [31:0] ctr);
		state_t s;
		s[0] = SIGMA_0;
		s[1] = SIGMA_1;
		s[2] = SIGMA_2;
		s[3] = SIGMA_3;
		for (int i = 0; i < 4; i++) begin
			s[4 + 2 * i] = key[i][31:0];
			s[5 + 2 * i] = key[i][63:32];
		end
		s[12] = ctr;
		s[13] = nonce01[31:0];
		s[14] = nonce01[63:32];
		s[15] = nonce2;
		return s;
	endfunction

endpackage

// File: hw/rtl/cc20_in_if.sv
// input stream channel: message words with byte count and last flag
interface cc20_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic        last_word;

	modport source (output valid, output data_word, output byte_count, output last_word,
		input ready);
	modport sink (input valid, input data_word, input byte_count, input last_word,
		output ready);
endinterface

// File: hw/rtl/cc20_out_if.sv
// output stream channel: ciphered words with byte count and last flag
interface cc20_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_word;
	logic [3:0]  out_byte_count;
	logic        out_last;

	modport source (output valid, output out_word, output out_byte_count, output out_last,
		input ready);
	modport sink (input valid, input out_word, input out_byte_count, input out_last,
		output ready);
endinterface

// File: hw/rtl/chacha20_stream_cipher.sv
// chacha20 stream cipher top level: config registers, sequencer, keystream store, output
// path: a word that opens a keystream block passes the round-unit steps, the final add and
// the output load before it is registered at the output; other words go straight to the output load
// the rate is set by the shared round unit, which does half a quarter round on four lanes per
// cycle; one word is worked on at a time
// reset: arst_n clears the sequencer, counters, message state and config registers to zero
module chacha20_stream_cipher
	import cc20_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	cc20_in_if.sink           din,
	cc20_out_if.source        dout,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready
);

	// sequencer states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ROUND = 2'd1;
	localparam logic [1:0] S_FINAL = 2'd2;
	localparam logic [1:0] S_EMIT  = 2'd3;

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;

	// configuration registers
	key_t        key_q;
	logic [63:0] nonce01_q;
	logic [31:0] nonce2_q;
	logic [31:0] start_ctr_q;

	// message state
	logic [31:0] blk_ctr_q;
	logic [2:0]  pos_q;
	logic        active_q;

	// held input word
	logic [63:0] data_q;
	logic [3:0]  cnt_q;
	logic        last_q;

	// working state of the block function and the finished keystream block
	state_t w_q;
	state_t ks_q;
	state_t w_nxt;

	// output register
	logic        out_valid_q;
	logic [63:0] out_word_q;
	logic [3:0]  out_cnt_q;
	logic        out_last_q;

	logic        in_acc;
	logic        out_free;
	logic        need_blk;
	logic        cfg_wr;
	logic [2:0]  cfg_idx;
	logic [31:0] ctr_eff;
	logic [3:0]  cnt_sat;
	state_t      init_acc;
	state_t      init_fin;
	logic [63:0] ks_word;
	logic [63:0] byte_mask;

	// apb side: no wait states (pready tied high), registers decoded on paddr[5:3]
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = paddr[5:3];

	always_comb begin
		case (cfg_idx)
			REG_KEY_01:   prdata = key_q[0];
			REG_KEY_23:   prdata = key_q[1];
			REG_KEY_45:   prdata = key_q[2];
			REG_KEY_67:   prdata = key_q[3];
			REG_NONCE_01: prdata = nonce01_q;
			REG_NONCE_2:  prdata = {32'd0, nonce2_q};
			REG_START:    prdata = {32'd0, start_ctr_q};
			default:      prdata = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q       <= '0;
			nonce01_q   <= '0;
			nonce2_q    <= '0;
			start_ctr_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_KEY_01:   key_q[0]    <= pwdata;
				REG_KEY_23:   key_q[1]    <= pwdata;
				REG_KEY_45:   key_q[2]    <= pwdata;
				REG_KEY_67:   key_q[3]    <= pwdata;
				REG_NONCE_01: nonce01_q   <= pwdata;
				REG_NONCE_2:  nonce2_q    <= pwdata[31:0];
				REG_START:    start_ctr_q <= pwdata[31:0];
				default:      ;
			endcase
		end
	end

	// stream handshakes: one word in flight, output register frees the input side
	assign din.ready           = (state_q == S_IDLE);
	assign in_acc              = din.valid & din.ready;
	assign out_free            = !out_valid_q || dout.ready;
	assign dout.valid          = out_valid_q;
	assign dout.out_word       = out_word_q;
	assign dout.out_byte_count = out_cnt_q;
	assign dout.out_last       = out_last_q;

	// a new message reloads the counter; a block is made at slot zero
	assign ctr_eff  = active_q ? blk_ctr_q : start_ctr_q;
	assign need_blk = !active_q || (pos_q == 3'd0);
	assign cnt_sat  = (din.byte_count > MAX_BYTES) ? MAX_BYTES : din.byte_count;

	// block input state; counter already settled by the time of the final add
	assign init_acc = init_state(key_q, nonce01_q, nonce2_q, ctr_eff);
	assign init_fin = init_state(key_q, nonce01_q, nonce2_q, blk_ctr_q);

	// step bit 0 picks the half of the quarter round, bit 1 column or diagonal
	cc20_round u_round (
		.cur  (w_q),
		.diag (step_q[1]),
		.half (step_q[0]),
		.nxt  (w_nxt)
	);

	// keystream slot of this word, and the valid-byte mask
	assign ks_word = {ks_q[{pos_q, 1'b1}], ks_q[{pos_q, 1'b0}]};

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			byte_mask[8 * j +: 8] = {8{(4'(j) < cnt_q)}};
		end
	end

	// sequencer and message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			blk_ctr_q   <= '0;
			pos_q       <= '0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!active_q) begin
							blk_ctr_q <= start_ctr_q;
							pos_q     <= '0;
							active_q  <= 1'b1;
						end
						step_q  <= '0;
						state_q <= need_blk ? S_ROUND : S_EMIT;
					end
				end
				S_ROUND: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(ROUND_STEPS - 1)) begin
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						pos_q <= pos_q + 1'b1;
						if (pos_q == 3'd7) begin
							blk_ctr_q <= blk_ctr_q + 1'b1;
						end
						if (last_q) begin
							active_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload path, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_q <= din.data_word;
			cnt_q  <= cnt_sat;
			last_q <= din.last_word;
			w_q    <= init_acc;
		end else if (state_q == S_ROUND) begin
			w_q <= w_nxt;
		end
		if (state_q == S_FINAL) begin
			for (int i = 0; i < 16; i++) begin
				ks_q[i] <= w_q[i] + init_fin[i];
			end
		end
		if (state_q == S_EMIT && out_free) begin
			out_word_q <= (data_q ^ ks_word) & byte_mask;
			out_cnt_q  <= cnt_q;
			out_last_q <= last_q;
		end
	end

endmodule

// File: hw/rtl/cc20_round.sv
// shared round unit: half a quarter round on four lanes, column or diagonal
module cc20_round
	import cc20_pkg::*;
(
	input  state_t cur,
	input  logic   diag,
	input  logic   half,
	output state_t nxt
);

	always_comb begin
		logic [1:0]  sb, sc, sd;
		logic [3:0]  ia, ib, ic, id;
		logic [31:0] a, b, c, d;
		nxt = cur;
		for (int i = 0; i < 4; i++) begin
			// diagonal lanes shift rows one, two and three places
			sb = 2'(i) + {1'b0, diag};
			sc = 2'(i) + {diag, 1'b0};
			sd = 2'(i) + {diag, diag};
			ia = {2'b00, 2'(i)};
			ib = {2'b01, sb};
			ic = {2'b10, sc};
			id = {2'b11, sd};
			a = cur[ia];
			b = cur[ib];
			c = cur[ic];
			d = cur[id];
			a = a + b;
			d = d ^ a;
			d = half ? rotl(d, ROT_C) : rotl(d, ROT_A);
			c = c + d;
			b = b ^ c;
			b = half ? rotl(b, ROT_D) : rotl(b, ROT_B);
			nxt[ia] = a;
			nxt[ib] = b;
			nxt[ic] = c;
			nxt[id] = d;
		end
	end

endmodule

// File: hw/rtl/cc20_checker.sv
// port-level checker for the chacha20 stream cipher, bound to the top level
module cc20_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] out_word,
	input logic [3:0]  out_byte_count,
	input logic        out_last
);

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	// a stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_word) && $stable(out_byte_count)
			&& $stable(out_last))
		else $error("output payload changed while stalled");

	// one word at a time: input closes right after a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an input transaction");

	// byte count never above eight, bytes beyond the count are zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_byte_count <= 4'd8)
		else $error("output byte count above eight");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_byte_count < 4'd8 |-> (out_word >> {out_byte_count, 3'b000}) == 64'd0)
		else $error("output bytes beyond the count are not zero");

endmodule

bind chacha20_stream_cipher cc20_checker u_cc20_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (din.valid),
	.in_ready       (din.ready),
	.out_valid      (dout.valid),
	.out_ready      (dout.ready),
	.out_word       (dout.out_word),
	.out_byte_count (dout.out_byte_count),
	.out_last       (dout.out_last)
);
